[src/bts_pkg.sv]
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types, constants and note tables of the buzzer tone sequencer.
// ----------------------------------------------------------------------------
package bts_pkg;

	// melody length default and table depth
	localparam int unsigned NOTE_COUNT_DEF = 23;
	localparam int unsigned TUNE_DEPTH     = 32;
	localparam int unsigned NOTE_IDX_W     = $clog2(TUNE_DEPTH);

	// remainder unit widths
	localparam int unsigned DIVIDEND_W = 32;
	localparam int unsigned DIVISOR_W  = 16;

	// time and pattern constants
	localparam logic [31:0] MIN_TIME_MS  = 32'd5000;
	localparam logic [15:0] REST_FREQ    = 16'd1;
	localparam logic [15:0] FAST_FREQ    = 16'd2000;
	localparam logic [15:0] SLOW_FREQ    = 16'd432;
	localparam logic [15:0] FAST_PERIOD  = 16'd1000;
	localparam logic [15:0] SLOW_PERIOD  = 16'd3000;
	localparam logic [15:0] PATTERN_ON   = 16'd500;

	// error pattern codes
	localparam logic [6:0] MODE_FAST   = 7'd0;
	localparam logic [6:0] MODE_SLOW   = 7'd1;
	localparam logic [6:0] MODE_MELODY = 7'd2;
	localparam logic [6:0] MODE_CUSTOM = 7'd127;

	// input item codes
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_COMMAND = 1'b1;

	// register reset values
	localparam logic [6:0]  MODE_RST   = 7'd0;
	localparam logic [15:0] C_FREQ_RST = 16'd2000;
	localparam logic [15:0] C_PER_RST  = 16'd1000;
	localparam logic [15:0] C_SND_RST  = 16'd500;

	// register map, word index
	typedef enum logic [1:0] {
		REG_MODE   = 2'd0,
		REG_C_FREQ = 2'd1,
		REG_C_PER  = 2'd2,
		REG_C_SND  = 2'd3
	} reg_idx_t;

	localparam int unsigned PADDR_W = 4;

	typedef struct packed {
		logic [6:0]  melody_mode;
		logic [15:0] custom_frequency_hz;
		logic [15:0] custom_period_ms;
		logic [15:0] custom_sound_ms;
	} cfg_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} rem_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIVISOR_W-1:0] remainder;
	} rem_rsp_t;

	// melody note tables, notes past the tune are rests
	localparam logic [15:0] TUNE_FREQ [TUNE_DEPTH] = '{
		16'd659, 16'd784, 16'd784, 16'd659, 16'd880, 16'd784, 16'd880, 16'd784,
		16'd880, 16'd784, 16'd880, 16'd784, 16'd880, 16'd988, 16'd659, 16'd784,
		16'd784, 16'd659, 16'd880, 16'd784, 16'd880, 16'd784, 16'd880,
		16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1
	};

	localparam logic [15:0] TUNE_DELAY [TUNE_DEPTH] = '{
		16'd207, 16'd1241, 16'd207, 16'd1241, 16'd207, 16'd207, 16'd207, 16'd207,
		16'd207, 16'd207, 16'd207, 16'd207, 16'd207, 16'd1241, 16'd207, 16'd1241,
		16'd207, 16'd1241, 16'd207, 16'd207, 16'd207, 16'd207, 16'd207,
		16'd207, 16'd207, 16'd207, 16'd207, 16'd207, 16'd207, 16'd207, 16'd207,
		16'd207
	};

endpackage

[src/bts_in_if.sv]
// ----------------------------------------------------------------------------
// bts_in_if
// Request channel carrying ticks and beep commands.
// ----------------------------------------------------------------------------
interface bts_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [31:0] time_ms;
	logic [7:0]  error_in;
	logic [15:0] cmd_frequency_hz;
	logic [23:0] cmd_duration_ms;

	modport source (
		output valid, op, time_ms, error_in, cmd_frequency_hz, cmd_duration_ms,
		input  ready
	);
	modport sink (
		input  valid, op, time_ms, error_in, cmd_frequency_hz, cmd_duration_ms,
		output ready
	);
endinterface

[src/bts_out_if.sv]
// ----------------------------------------------------------------------------
// bts_out_if
// Result channel carrying the buzzer drive.
// ----------------------------------------------------------------------------
interface bts_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] tone_frequency_hz;
	logic        tone_enable;

	modport source (
		output valid, tone_frequency_hz, tone_enable,
		input  ready
	);
	modport sink (
		input  valid, tone_frequency_hz, tone_enable,
		output ready
	);
endinterface

[src/bts_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bts_cfg_regs
// APB register file holding the error pattern settings.
// ----------------------------------------------------------------------------
module bts_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bts_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output bts_pkg::cfg_t                cfg
);
	import bts_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.melody_mode         <= MODE_RST;
			cfg_q.custom_frequency_hz <= C_FREQ_RST;
			cfg_q.custom_period_ms    <= C_PER_RST;
			cfg_q.custom_sound_ms     <= C_SND_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_MODE:   cfg_q.melody_mode         <= pwdata[6:0];
				REG_C_FREQ: cfg_q.custom_frequency_hz <= pwdata[15:0];
				REG_C_PER:  cfg_q.custom_period_ms    <= pwdata[15:0];
				REG_C_SND:  cfg_q.custom_sound_ms     <= pwdata[15:0];
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_MODE:   prdata = {25'd0, cfg_q.melody_mode};
			REG_C_FREQ: prdata = {16'd0, cfg_q.custom_frequency_hz};
			REG_C_PER:  prdata = {16'd0, cfg_q.custom_period_ms};
			REG_C_SND:  prdata = {16'd0, cfg_q.custom_sound_ms};
		endcase
	end

endmodule

[src/bts_rem_unit.sv]
// ----------------------------------------------------------------------------
// bts_rem_unit
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module bts_rem_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  bts_pkg::rem_req_t req,
	output bts_pkg::rem_rsp_t rsp
);
	import bts_pkg::*;

	localparam int unsigned CntW = $clog2(DIVIDEND_W);
	localparam logic [CntW-1:0] LastCnt = CntW'(DIVIDEND_W - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CntW-1:0]       cnt_q;
	logic [DIVIDEND_W-1:0] dvd_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic [DIVISOR_W-1:0]  rem_next;

	// one shift and trial subtract
	always_comb begin
		trial = {rem_q, dvd_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, dvs_q};
		if (trial >= {1'b0, dvs_q}) begin
			rem_next = diff[DIVISOR_W-1:0];
		end else begin
			rem_next = trial[DIVISOR_W-1:0];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LastCnt);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LastCnt) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIVIDEND_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

[src/buzzer_tone_pattern_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// buzzer_tone_pattern_sequencer_unit
// Alarm buzzer tone sequencer: error patterns, melody and commanded beeps.
// ----------------------------------------------------------------------------
//  channel  dir  handshake       payload
//  item     in   valid/ready     op, time_ms, error_in, cmd_frequency_hz,
//                                cmd_duration_ms
//  tone     out  valid/ready     tone_frequency_hz, tone_enable
//  apb      in   psel/penable    paddr, pwdata, prdata (pready tied high)
//
//  commands, early ticks and ticks needing no remainder pass idle, eval, fin
//  late alarm ticks of fast, slow and custom patterns also pass div, where
//  the 32-step remainder unit works the tick time modulo the pattern period
//  reset clears the control and block state at once, no clearing pass
//  the result register holds a result until taken; the next item is
//  accepted meanwhile and waits in its last step for the register to free
// ----------------------------------------------------------------------------
module buzzer_tone_pattern_sequencer_unit #(
	parameter int unsigned NOTE_COUNT = bts_pkg::NOTE_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	bts_in_if.sink                       item,
	bts_out_if.source                    tone,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bts_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import bts_pkg::*;

	localparam logic [NOTE_IDX_W-1:0] NoteLimit = NOTE_IDX_W'(NOTE_COUNT);

	cfg_t     cfg;
	rem_req_t rem_req;
	rem_rsp_t rem_rsp;
	state_t   state_q, state_next;

	// captured request
	logic        op_q;
	logic [31:0] now_q;
	logic [7:0]  err_q;
	logic [15:0] cfreq_q;
	logic [23:0] cdur_q;

	// block state
	logic                  err_latched_q;
	logic [15:0]           drive_freq_q;
	logic                  drive_en_q;
	logic [31:0]           last_time_q;
	logic [31:0]           cmd_end_q;
	logic [15:0]           cmd_freq_q;
	logic [NOTE_IDX_W-1:0] note_idx_q;
	logic [31:0]           note_start_q;
	logic                  mel_started_q;

	// result register
	logic        out_valid_q;
	logic [15:0] out_freq_q;
	logic        out_en_q;

	// tick decode
	logic        late_tick;
	logic        err_now;
	logic        need_div;
	logic [15:0] div_period;
	logic        out_free;

	// melody step
	logic [31:0]           mel_start;
	logic [31:0]           mel_delta;
	logic                  mel_in_tune;
	logic                  mel_advance;

	// pattern compare after the remainder
	logic [15:0] pat_on_ms;
	logic [15:0] pat_freq;

	bts_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bts_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	// tick classification
	always_comb begin
		late_tick  = (op_q == OP_TICK) && (now_q >= MIN_TIME_MS);
		err_now    = err_latched_q || (err_q != 8'd0);
		div_period = cfg.custom_period_ms;
		need_div   = 1'b0;
		if (cfg.melody_mode == MODE_FAST) begin
			div_period = FAST_PERIOD;
			need_div   = 1'b1;
		end else if (cfg.melody_mode == MODE_SLOW) begin
			div_period = SLOW_PERIOD;
			need_div   = 1'b1;
		end else if (cfg.melody_mode == MODE_CUSTOM) begin
			need_div = (cfg.custom_period_ms != 16'd0);
		end
		need_div = need_div && late_tick && err_now;
		out_free = !out_valid_q || tone.ready;
	end

	// melody note step
	always_comb begin
		mel_start   = mel_started_q ? note_start_q : now_q;
		mel_delta   = now_q - mel_start;
		mel_in_tune = (note_idx_q < NoteLimit);
		mel_advance = mel_delta > {16'd0, TUNE_DELAY[note_idx_q]};
	end

	// pattern tone and sounding window
	always_comb begin
		pat_on_ms = PATTERN_ON;
		pat_freq  = FAST_FREQ;
		if (cfg.melody_mode == MODE_CUSTOM) begin
			pat_on_ms = cfg.custom_sound_ms;
			pat_freq  = cfg.custom_frequency_hz;
		end else if (cfg.melody_mode == MODE_SLOW) begin
			pat_freq = SLOW_FREQ;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// sequencer
	always_comb begin
		state_next       = state_q;
		item.ready       = 1'b0;
		rem_req.start    = 1'b0;
		rem_req.dividend = now_q;
		rem_req.divisor  = div_period;
		unique case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					state_next = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (need_div) begin
					rem_req.start = 1'b1;
					state_next    = ST_DIV;
				end else begin
					state_next = ST_FIN;
				end
			end
			ST_DIV: begin
				if (rem_rsp.done) begin
					state_next = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
		endcase
	end

	// request capture
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_q    <= item.op;
			now_q   <= item.time_ms;
			err_q   <= item.error_in;
			cfreq_q <= item.cmd_frequency_hz;
			cdur_q  <= item.cmd_duration_ms;
		end
	end

	// block state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_latched_q <= 1'b0;
			drive_freq_q  <= REST_FREQ;
			drive_en_q    <= 1'b0;
			last_time_q   <= '0;
			cmd_end_q     <= '0;
			cmd_freq_q    <= '0;
			note_idx_q    <= '0;
			note_start_q  <= '0;
			mel_started_q <= 1'b0;
		end else if (state_q == ST_EVAL) begin
			if (op_q == OP_COMMAND) begin
				cmd_freq_q <= cfreq_q;
				cmd_end_q  <= last_time_q + 32'(cdur_q);
			end else begin
				last_time_q <= now_q;
				if (late_tick) begin
					err_latched_q <= err_now;
					if (err_now) begin
						// pattern with no division
						if (cfg.melody_mode == MODE_CUSTOM &&
						    cfg.custom_period_ms == 16'd0) begin
							drive_freq_q <= REST_FREQ;
							drive_en_q   <= 1'b1;
						end else if (cfg.melody_mode == MODE_MELODY) begin
							mel_started_q <= 1'b1;
							drive_en_q    <= 1'b1;
							if (mel_in_tune) begin
								drive_freq_q <= TUNE_FREQ[note_idx_q];
								note_start_q <= mel_advance ? now_q : mel_start;
								if (mel_advance) begin
									note_idx_q <= note_idx_q + 1'b1;
								end
							end else begin
								drive_freq_q <= REST_FREQ;
								note_start_q <= mel_start;
								note_idx_q   <= '0;
							end
						end
					end else if (now_q < cmd_end_q) begin
						drive_freq_q <= cmd_freq_q;
						drive_en_q   <= 1'b1;
					end else begin
						drive_en_q <= 1'b0;
					end
				end
			end
		end else if (state_q == ST_DIV && rem_rsp.done) begin
			drive_en_q   <= 1'b1;
			drive_freq_q <= (rem_rsp.remainder < pat_on_ms) ? pat_freq : REST_FREQ;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (tone.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_freq_q <= drive_freq_q;
			out_en_q   <= drive_en_q;
		end
	end

	assign tone.valid             = out_valid_q;
	assign tone.tone_frequency_hz = out_freq_q;
	assign tone.tone_enable       = out_en_q;

endmodule

[src/bts_sva.sv]
// ----------------------------------------------------------------------------
// bts_sva
// Port level checks of the buzzer tone sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module bts_sva (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        tone_valid,
	input logic        tone_ready,
	input logic [15:0] tone_freq,
	input logic        tone_en
);

	// a waiting result holds until taken
	a_tone_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tone_valid && !tone_ready |=> tone_valid && $stable(tone_freq) && $stable(tone_en))
		else $error("tone result dropped or changed while stalled");

	// the block is busy right after taking a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("request taken while previous one in work");

	// a new result only appears from a request in work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tone_valid) |-> !$past(item_ready))
		else $error("result appeared without a request in work");

	// no two requests closer than the minimum item time
	a_min_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> ##1 !item_ready)
		else $error("requests accepted too close together");

endmodule

bind buzzer_tone_pattern_sequencer_unit bts_sva u_bts_sva (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item.valid),
	.item_ready (item.ready),
	.tone_valid (tone.valid),
	.tone_ready (tone.ready),
	.tone_freq  (tone.tone_frequency_hz),
	.tone_en    (tone.tone_enable)
);

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the buzzer tone pattern sequencer.
// Directed rows cover early ticks, beep expiry and wrap, and every alarm
// pattern with its corner settings. Random beep traffic, with no error
// latched, runs before the alarm rows. Random alarm phases follow, one
// register setting each. Every request is predicted in the bench and checked
// against the tone results in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bts_pkg::*;

	localparam int unsigned NOTES        = NOTE_COUNT_DEF;
	localparam int unsigned LIMIT_CYCLES = 1_000_000;
	localparam int unsigned DRAIN_CYCLES = 60;

	// alarm pattern codes with no defined pattern, drive is held
	localparam logic [6:0] MODE_HOLD_A = 7'd3;
	localparam logic [6:0] MODE_HOLD_B = 7'd64;
	localparam logic [6:0] MODE_HOLD_C = 7'd126;

	typedef struct packed {
		logic        op;
		logic [31:0] time_ms;
		logic [7:0]  error_in;
		logic [15:0] cmd_frequency_hz;
		logic [23:0] cmd_duration_ms;
	} beep_req_t;

	typedef struct packed {
		logic [15:0] freq;
		logic        en;
	} tone_t;

	typedef struct {
		logic        is_reg;
		reg_idx_t    reg_sel;
		logic [15:0] reg_val;
		beep_req_t   req;
		logic        typed;
		tone_t       want;
	} plan_row_t;

	typedef struct {
		logic [6:0]  mode;
		logic [15:0] freq;
		logic [15:0] per;
		logic [15:0] snd;
		int          n;
		logic        quiet;
	} alarm_phase_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	bts_in_if  item_ch ();
	bts_out_if tone_ch ();

	buzzer_tone_pattern_sequencer_unit #(
		.NOTE_COUNT(NOTES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.tone   (tone_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// predictor state and register shadow
	logic        err_latched;
	logic [15:0] drv_freq;
	logic        drv_en;
	logic [31:0] last_ms;
	logic [31:0] cmd_end_ms;
	logic [15:0] cmd_freq;
	logic [4:0]  note_idx;
	logic [31:0] note_t0;
	logic        melody_on;
	logic [6:0]  cfg_mode;
	logic [15:0] cfg_freq;
	logic [15:0] cfg_per;
	logic [15:0] cfg_snd;

	tone_t        tone_due [$];
	plan_row_t    beep_plan [$];
	alarm_phase_t alarm_plan [$];
	int           miss_count;
	int unsigned  cycles;
	int           stall_left;
	logic         no_idle;
	logic [31:0]  clock_ms;
	int           err_row;

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic void sound(logic [15:0] f);
		drv_freq = f;
		drv_en   = 1'b1;
	endfunction

	function automatic void melody_step(logic [31:0] now);
		logic [4:0]  idx;
		logic [31:0] since;
		if (!melody_on) begin
			note_t0   = now;
			melody_on = 1'b1;
		end
		idx = note_idx;
		if (idx < NOTES) begin
			sound(TUNE_FREQ[idx]);
			since = now - note_t0;
			if (since > 32'(TUNE_DELAY[idx])) begin
				note_t0  = now;
				note_idx = idx + 5'd1;
			end
		end else begin
			note_idx = '0;
			sound(REST_FREQ);
		end
	endfunction

	function automatic void alarm_step(logic [31:0] now);
		case (cfg_mode)
			MODE_CUSTOM: begin
				if (cfg_per != 16'd0 && (now % 32'(cfg_per)) < 32'(cfg_snd))
					sound(cfg_freq);
				else
					sound(REST_FREQ);
			end
			MODE_FAST: sound((now % 32'(FAST_PERIOD)) < 32'(PATTERN_ON) ? FAST_FREQ : REST_FREQ);
			MODE_SLOW: sound((now % 32'(SLOW_PERIOD)) < 32'(PATTERN_ON) ? SLOW_FREQ : REST_FREQ);
			MODE_MELODY: melody_step(now);
			default: ;
		endcase
	endfunction

	function automatic tone_t predict_tone(beep_req_t r);
		tone_t t;
		if (r.op == OP_COMMAND) begin
			cmd_freq   = r.cmd_frequency_hz;
			cmd_end_ms = last_ms + 32'(r.cmd_duration_ms);
		end else begin
			last_ms = r.time_ms;
			if (r.time_ms >= MIN_TIME_MS) begin
				if (r.error_in != 8'd0)
					err_latched = 1'b1;
				if (err_latched)
					alarm_step(r.time_ms);
				else if (r.time_ms < cmd_end_ms)
					sound(cmd_freq);
				else
					drv_en = 1'b0;
			end
		end
		t.freq = drv_freq;
		t.en   = drv_en;
		return t;
	endfunction

	// ------------------------------------------------------------------
	// request builders, unused fields carry noise
	// ------------------------------------------------------------------
	function automatic beep_req_t mk_tick(logic [31:0] t, logic [7:0] e);
		beep_req_t r;
		r.op               = OP_TICK;
		r.time_ms          = t;
		r.error_in         = e;
		r.cmd_frequency_hz = 16'($urandom);
		r.cmd_duration_ms  = 24'($urandom);
		return r;
	endfunction

	function automatic beep_req_t mk_cmd(logic [15:0] f, logic [23:0] d);
		beep_req_t r;
		r.op               = OP_COMMAND;
		r.time_ms          = $urandom;
		r.error_in         = 8'($urandom);
		r.cmd_frequency_hz = f;
		r.cmd_duration_ms  = d;
		return r;
	endfunction

	function automatic plan_row_t item_row(beep_req_t r, logic typed, logic [15:0] f,
			logic en);
		plan_row_t p;
		p.is_reg  = 1'b0;
		p.reg_sel = REG_MODE;
		p.reg_val = '0;
		p.req     = r;
		p.typed   = typed;
		p.want    = '{f, en};
		return p;
	endfunction

	function automatic plan_row_t reg_row(reg_idx_t s, logic [15:0] v);
		plan_row_t p;
		p         = item_row(mk_tick(32'd0, 8'd0), 1'b0, '0, 1'b0);
		p.is_reg  = 1'b1;
		p.reg_sel = s;
		p.reg_val = v;
		return p;
	endfunction

	// ------------------------------------------------------------------
	// idle lengths: mostly none or short, a few long
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// ------------------------------------------------------------------
	// mismatch reporting
	// ------------------------------------------------------------------
	function automatic void flag_miss(string what, logic [31:0] want, logic [31:0] got);
		miss_count++;
		if (miss_count <= 10)
			$display("mismatch %s: expected %0d, got %0d", what, want, got);
	endfunction

	// ------------------------------------------------------------------
	// request channel driver
	// ------------------------------------------------------------------
	task automatic send_req(beep_req_t r, logic typed, tone_t want);
		int    gap;
		tone_t t;
		gap = pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid            <= 1'b1;
		item_ch.op               <= r.op;
		item_ch.time_ms          <= r.time_ms;
		item_ch.error_in         <= r.error_in;
		item_ch.cmd_frequency_hz <= r.cmd_frequency_hz;
		item_ch.cmd_duration_ms  <= r.cmd_duration_ms;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		t = predict_tone(r);
		tone_due.push_back(typed ? want : t);
	endtask

	// stop requests and wait for every tone result
	task automatic quiesce();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (tone_due.size() != 0) @(posedge clk);
	endtask

	// register write then read back
	task automatic set_reg(reg_idx_t s, logic [15:0] v);
		logic [31:0] want;
		want = (s == REG_MODE) ? 32'(v[6:0]) : 32'(v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {s, 2'b00};
		pwdata  <= 32'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (s)
			REG_MODE:   cfg_mode = v[6:0];
			REG_C_FREQ: cfg_freq = v;
			REG_C_PER:  cfg_per  = v;
			REG_C_SND:  cfg_snd  = v;
			default: ;
		endcase
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want)
			flag_miss("register readback", want, prdata);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_plan(int lo, int hi);
		for (int i = lo; i < hi; i++) begin
			if (beep_plan[i].is_reg) begin
				quiesce();
				set_reg(beep_plan[i].reg_sel, beep_plan[i].reg_val);
			end else begin
				send_req(beep_plan[i].req, beep_plan[i].typed, beep_plan[i].want);
			end
		end
	endtask

	task automatic add_phase(logic [6:0] m, logic [15:0] f, logic [15:0] p,
			logic [15:0] s, int n, logic q);
		alarm_phase_t a;
		a.mode  = m;
		a.freq  = f;
		a.per   = p;
		a.snd   = s;
		a.n     = n;
		a.quiet = q;
		alarm_plan.push_back(a);
	endtask

	// ------------------------------------------------------------------
	// result channel: random stalls and in-order check
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			tone_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			tone_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			tone_ch.ready <= 1'b1;
			if (!no_idle && $urandom_range(0, 3) == 0)
				stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
					: $urandom_range(12, 40);
		end
	end

	always @(posedge clk) begin
		tone_t want;
		if (arst_n && tone_ch.valid && tone_ch.ready) begin
			if (tone_due.size() == 0) begin
				flag_miss("tone with no request pending", 32'd0,
					32'(tone_ch.tone_frequency_hz));
			end else begin
				want = tone_due.pop_front();
				if (tone_ch.tone_frequency_hz !== want.freq)
					flag_miss("tone frequency", 32'(want.freq),
						32'(tone_ch.tone_frequency_hz));
				if (tone_ch.tone_enable !== want.en)
					flag_miss("tone enable", 32'(want.en), 32'(tone_ch.tone_enable));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout at cycle %0d", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		beep_req_t    r;
		alarm_phase_t a;
		int           k;

		clk                      = 1'b0;
		arst_n                   = 1'b0;
		psel                     = 1'b0;
		penable                  = 1'b0;
		pwrite                   = 1'b0;
		paddr                    = '0;
		pwdata                   = '0;
		item_ch.valid            = 1'b0;
		item_ch.op               = OP_TICK;
		item_ch.time_ms          = '0;
		item_ch.error_in         = '0;
		item_ch.cmd_frequency_hz = '0;
		item_ch.cmd_duration_ms  = '0;
		tone_ch.ready            = 1'b0;
		miss_count               = 0;
		cycles                   = 0;
		stall_left               = 0;
		no_idle                  = 1'b0;

		err_latched = 1'b0;
		drv_freq    = REST_FREQ;
		drv_en      = 1'b0;
		last_ms     = '0;
		cmd_end_ms  = '0;
		cmd_freq    = '0;
		note_idx    = '0;
		note_t0     = '0;
		melody_on   = 1'b0;
		cfg_mode    = MODE_RST;
		cfg_freq    = C_FREQ_RST;
		cfg_per     = C_PER_RST;
		cfg_snd     = C_SND_RST;

		// beeps before any error: early ticks, expiry, end time wrap
		beep_plan.push_back(item_row(mk_tick(32'd0, 8'hFF), 1'b1, 16'd1, 1'b0));
		beep_plan.push_back(item_row(mk_tick(32'd4999, 8'h80), 1'b1, 16'd1, 1'b0));
		beep_plan.push_back(item_row(mk_cmd(16'hFFFF, 24'hFFFFFF), 1'b1, 16'd1, 1'b0));
		beep_plan.push_back(item_row(mk_tick(32'd5000, 8'h00), 1'b1, 16'hFFFF, 1'b1));
		beep_plan.push_back(item_row(mk_cmd(16'd0, 24'd0), 1'b1, 16'hFFFF, 1'b1));
		beep_plan.push_back(item_row(mk_tick(32'd5000, 8'h00), 1'b1, 16'hFFFF, 1'b0));
		beep_plan.push_back(item_row(mk_cmd(16'd1234, 24'd100), 1'b1, 16'hFFFF, 1'b0));
		beep_plan.push_back(item_row(mk_tick(32'd5099, 8'h00), 1'b1, 16'd1234, 1'b1));
		beep_plan.push_back(item_row(mk_tick(32'd5100, 8'h00), 1'b1, 16'd1234, 1'b0));
		beep_plan.push_back(item_row(mk_tick(32'hFFFF_FF00, 8'h00), 1'b1, 16'd1234, 1'b0));
		beep_plan.push_back(item_row(mk_cmd(16'd777, 24'h000200), 1'b1, 16'd1234, 1'b0));
		beep_plan.push_back(item_row(mk_tick(32'hFFFF_FFFF, 8'h00), 1'b1, 16'd1234, 1'b0));
		beep_plan.push_back(item_row(mk_tick(32'd4000, 8'h7F), 1'b1, 16'd1234, 1'b0));
		err_row = beep_plan.size();

		// error latch and every alarm pattern
		beep_plan.push_back(item_row(mk_tick(32'd6000, 8'h01), 1'b1, FAST_FREQ, 1'b1));
		beep_plan.push_back(reg_row(REG_MODE, 16'(MODE_SLOW)));
		beep_plan.push_back(item_row(mk_tick(32'd9000, 8'h00), 1'b1, SLOW_FREQ, 1'b1));
		beep_plan.push_back(reg_row(REG_MODE, 16'(MODE_CUSTOM)));
		beep_plan.push_back(reg_row(REG_C_PER, 16'd0));
		beep_plan.push_back(item_row(mk_tick(32'd10000, 8'h00), 1'b1, REST_FREQ, 1'b1));
		beep_plan.push_back(reg_row(REG_C_PER, 16'd1000));
		beep_plan.push_back(reg_row(REG_C_FREQ, 16'd0));
		beep_plan.push_back(item_row(mk_tick(32'd10000, 8'h00), 1'b1, 16'd0, 1'b1));
		beep_plan.push_back(reg_row(REG_MODE, 16'(MODE_HOLD_A)));
		beep_plan.push_back(item_row(mk_tick(32'd20000, 8'hFF), 1'b1, 16'd0, 1'b1));
		beep_plan.push_back(reg_row(REG_MODE, 16'(MODE_MELODY)));
		beep_plan.push_back(item_row(mk_tick(32'd30000, 8'h00), 1'b1, 16'd659, 1'b1));
		beep_plan.push_back(item_row(mk_tick(32'd30207, 8'h00), 1'b1, 16'd659, 1'b1));
		beep_plan.push_back(item_row(mk_tick(32'd30208, 8'h00), 1'b1, 16'd659, 1'b1));
		beep_plan.push_back(item_row(mk_tick(32'd30209, 8'h00), 1'b1, 16'd784, 1'b1));
		beep_plan.push_back(reg_row(REG_C_FREQ, 16'hFFFF));
		beep_plan.push_back(reg_row(REG_C_PER, 16'hFFFF));
		beep_plan.push_back(reg_row(REG_C_SND, 16'hFFFF));
		beep_plan.push_back(reg_row(REG_MODE, 16'(MODE_CUSTOM)));
		beep_plan.push_back(item_row(mk_tick(32'hFFFF_FFFF, 8'h00), 1'b1, 16'hFFFF, 1'b1));
		beep_plan.push_back(reg_row(REG_C_SND, 16'd0));
		beep_plan.push_back(item_row(mk_tick(32'd123456, 8'h00), 1'b1, REST_FREQ, 1'b1));

		// alarm phases: mode, frequency, period, sound, requests, no idling
		add_phase(MODE_FAST,   C_FREQ_RST, C_PER_RST, C_SND_RST, 110, 1'b0);
		add_phase(MODE_SLOW,   16'd500,    16'd300,   16'd20,    110, 1'b1);
		add_phase(MODE_MELODY, 16'd900,    16'd50,    16'd25,    220, 1'b0);
		add_phase(MODE_CUSTOM, 16'd3000,   16'd700,   16'd350,   100, 1'b0);
		add_phase(MODE_CUSTOM, 16'hFFFF,   16'hFFFF,  16'hFFFF,  60,  1'b0);
		add_phase(MODE_CUSTOM, 16'd1,      16'd1,     16'd0,     50,  1'b1);
		add_phase(MODE_CUSTOM, 16'd440,    16'd7,     16'd9,     50,  1'b0);
		add_phase(MODE_CUSTOM, 16'd100,    16'd0,     16'd500,   40,  1'b0);
		add_phase(MODE_HOLD_A, 16'd1,      16'd1,     16'd1,     40,  1'b0);
		add_phase(MODE_HOLD_B, 16'd250,    16'd60000, 16'd30000, 40,  1'b0);
		add_phase(MODE_HOLD_C, 16'd8,      16'd3,     16'd2,     40,  1'b1);
		add_phase(MODE_MELODY, 16'd1200,   16'd2500,  16'd1000,  160, 1'b1);
		add_phase(MODE_FAST,   C_FREQ_RST, C_PER_RST, C_SND_RST, 60,  1'b0);

		// reset
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_plan(0, err_row);

		// random beeps with no error at or after the minimum time
		clock_ms = 32'd5000;
		for (int i = 0; i < 360; i++) begin
			no_idle = ((i / 60) % 3 == 2);
			k = $urandom_range(0, 99);
			if (k < 25) begin
				k = $urandom_range(0, 19);
				r = mk_cmd(k == 0 ? 16'hFFFF : (k == 1 ? 16'd0 : 16'($urandom)),
					k < 3 ? 24'($urandom) : (k == 3 ? 24'd0 : 24'($urandom_range(0, 1500))));
			end else if (k < 30) begin
				r = mk_tick($urandom_range(0, 4999), 8'($urandom));
			end else if (k < 34) begin
				r = mk_tick($urandom, 8'h00);
			end else if (k < 37) begin
				r = mk_tick(32'hFFFF_FFFF - $urandom_range(0, 3000), 8'h00);
			end else begin
				clock_ms = clock_ms + $urandom_range(0, 200);
				r = mk_tick(clock_ms, 8'h00);
			end
			if (r.op == OP_TICK && r.time_ms >= MIN_TIME_MS)
				clock_ms = r.time_ms;
			send_req(r, 1'b0, '0);
		end
		no_idle = 1'b0;

		run_plan(err_row, beep_plan.size());

		// random alarm phases
		clock_ms = 32'd40000;
		foreach (alarm_plan[p]) begin
			a = alarm_plan[p];
			quiesce();
			set_reg(REG_C_FREQ, a.freq);
			set_reg(REG_C_PER, a.per);
			set_reg(REG_C_SND, a.snd);
			set_reg(REG_MODE, 16'(a.mode));
			no_idle = a.quiet;
			for (int i = 0; i < a.n; i++) begin
				k = $urandom_range(0, 39);
				if (k < 4) begin
					r = mk_cmd(16'($urandom), 24'($urandom));
				end else if (k == 4) begin
					r = mk_tick($urandom, 8'($urandom));
				end else if (k == 5) begin
					r = mk_tick($urandom_range(0, 4999), 8'($urandom));
				end else begin
					clock_ms = clock_ms + ((a.mode == MODE_MELODY) ? $urandom_range(1, 400)
						: $urandom_range(1, 900));
					r = mk_tick(clock_ms, $urandom_range(0, 1) ? 8'h00 : 8'($urandom));
				end
				send_req(r, 1'b0, '0);
			end
			no_idle = 1'b0;
		end

		// drain
		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (miss_count == 0 && tone_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
